@@ rtl/lzd_pkg.sv @@
// lzd_pkg: shared constants for the LZ escape decompressor.
// Field widths, status codes and register reset values.
// No dependencies.
package lzd_pkg;

    localparam int unsigned WINDOW_BYTES_DEF = 4096;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 12;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_BAD_OFF   = 2'd1;
    localparam status_t ST_BUSY      = 2'd2;
    localparam status_t ST_NO_COPY   = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ESCAPE = 1'b0,
        REG_COPY   = 1'b1
    } cfg_reg_t;

    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'hF0;
    localparam logic [BYTE_W-1:0] COPY_RST   = 8'h01;

endpackage

@@ rtl/lz_escape_decompressor.sv @@
// lz_escape_decompressor: escape-byte LZ77 decoder with a sliding history window.
// Depends on lzd_pkg and lzd_hist_ram.
//
//  channel | direction | handshake       | payload
//  s       | in        | s_tvalid/tready | tdata {start_of_block, in_byte}, tuser command
//  m       | out       | m_tvalid/tready | tdata {status, copy_left, out_byte}, tuser out_valid
//  cfg     | in        | cfg_we          | cfg_index, cfg_wdata
//
// One item per cycle while m_tready holds; path: read stage, then result register.
// Parse and copy state update in the accept cycle; the history byte read for a
// copy step comes from the window RAM in the read stage, with forwarding from the
// byte written in the accept cycle. The history is not cleared: a copy only
// reaches bytes written since the block began. rst_n clears all control state.
// s_tready drops only while the result register is full and not being taken.
module lz_escape_decompressor #(
    parameter int unsigned WINDOW_BYTES = lzd_pkg::WINDOW_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] in_byte, [8] start_of_block, rest zero
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [19:8] copy_left, [21:20] status
    output logic        m_tuser,   // [0] out_valid
    input  logic                           cfg_we,
    input  logic [lzd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lzd_pkg::BYTE_W-1:0]     cfg_wdata
);

    localparam int unsigned AW = $clog2(WINDOW_BYTES);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned BW = lzd_pkg::BYTE_W;
    localparam int unsigned LW = lzd_pkg::LEN_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_B0,
        PH_B1,
        PH_B2
    } phase_t;

    // architectural state
    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    phase_t        phase_reg, phase_next;
    logic [BW-1:0] p0_reg, p0_next;
    logic [BW-1:0] p1_reg, p1_next;
    logic [LW-1:0] off_reg, off_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic [BW-1:0] esc_reg;
    logic [BW-1:0] cpy_reg;

    // read stage
    logic                   s1_valid_reg;
    logic                   s1_wr_reg, s1_wr_next;
    logic                   s1_lit_reg, s1_lit_next;
    logic                   s1_fwd_reg;
    logic [BW-1:0]          s1_byte_reg;
    logic [AW-1:0]          s1_addr_reg;
    logic [LW-1:0]          s1_left_reg;
    lzd_pkg::status_t       s1_status_reg, s1_status_next;
    logic [BW-1:0]          last_wd_reg;

    // result register
    logic                   m_valid_reg;
    logic                   m_outv_reg;
    logic [BW-1:0]          m_byte_reg;
    logic [LW-1:0]          m_left_reg;
    lzd_pkg::status_t       m_status_reg;

    logic          cmd;
    logic [BW-1:0] in_byte;
    logic          sob;
    logic          accept;
    logic          s1_adv;
    logic          rd_en;
    logic [AW-1:0] src_addr;
    logic [BW-1:0] ram_q;
    logic [BW-1:0] s1_data;
    logic          fwd_hit;

    logic [CW-1:0] base_cnt;
    logic [LW-1:0] base_rem;
    logic [LW-1:0] dec_off;
    logic [LW-1:0] dec_len;
    logic [AW-1:0] wp_inc;
    logic [CW-1:0] cnt_inc;
    logic          do_put;

    assign cmd     = s_tuser;
    assign in_byte = s_tdata[7:0];
    assign sob     = s_tdata[8];

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    assign base_cnt = sob ? '0 : cnt_reg;
    assign base_rem = sob ? '0 : rem_reg;
    assign dec_off  = {p0_reg, p1_reg[7:4]};
    assign dec_len  = {p1_reg[3:0], in_byte};

    assign wp_inc  = (wp_reg == AW'(WINDOW_BYTES - 1)) ? '0 : wp_reg + AW'(1);
    assign cnt_inc = (base_cnt == CW'(WINDOW_BYTES)) ? base_cnt : base_cnt + CW'(1);

    // source of a copy byte, wrapped inside the window
    always_comb
    begin
        if (wp_reg >= AW'(off_reg))
        begin
            src_addr = wp_reg - AW'(off_reg);
        end
        else
        begin
            src_addr = AW'({1'b0, wp_reg} + CW'(WINDOW_BYTES) - CW'(off_reg));
        end
    end

    always_comb
    begin
        phase_next     = sob ? PH_IDLE : phase_reg;
        p0_next        = sob ? '0 : p0_reg;
        p1_next        = sob ? '0 : p1_reg;
        off_next       = off_reg;
        rem_next       = base_rem;
        s1_wr_next     = 1'b0;
        s1_lit_next    = 1'b0;
        s1_status_next = lzd_pkg::ST_OK;
        rd_en          = 1'b0;

        if (cmd)
        begin
            if (base_rem == '0)
            begin
                s1_status_next = lzd_pkg::ST_NO_COPY;
            end
            else
            begin
                s1_wr_next = 1'b1;
                rd_en      = 1'b1;
                rem_next   = base_rem - LW'(1);
            end
        end
        else if (base_rem != '0)
        begin
            s1_status_next = lzd_pkg::ST_BUSY;
        end
        else
        begin
            unique case (phase_next)
                PH_IDLE:
                begin
                    if (in_byte == esc_reg)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        s1_wr_next  = 1'b1;
                        s1_lit_next = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    // escape wins over the copy code when both match
                    priority if (in_byte == esc_reg)
                    begin
                        s1_wr_next  = 1'b1;
                        s1_lit_next = 1'b1;
                        phase_next  = PH_IDLE;
                    end
                    else if (in_byte == cpy_reg)
                    begin
                        phase_next = PH_B0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_B0:
                begin
                    p0_next    = in_byte;
                    phase_next = PH_B1;
                end
                PH_B1:
                begin
                    p1_next    = in_byte;
                    phase_next = PH_B2;
                end
                PH_B2:
                begin
                    phase_next = PH_IDLE;
                    if (dec_off == '0 || CW'(dec_off) > base_cnt)
                    begin
                        s1_status_next = lzd_pkg::ST_BAD_OFF;
                    end
                    else
                    begin
                        off_next = dec_off;
                        rem_next = dec_len;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign do_put   = s1_wr_next;
    assign wp_next  = do_put ? wp_inc : wp_reg;
    assign cnt_next = do_put ? cnt_inc : base_cnt;

    // the item in the read stage writes its byte at this same edge
    assign fwd_hit = s1_valid_reg && s1_wr_reg && !s1_lit_reg ? (s1_addr_reg == src_addr)
                   : (s1_valid_reg && s1_wr_reg && (s1_addr_reg == src_addr));

    assign s1_data = s1_lit_reg ? s1_byte_reg : (s1_fwd_reg ? last_wd_reg : ram_q);

    lzd_hist_ram #(
        .DEPTH  (WINDOW_BYTES),
        .ADDR_W (AW),
        .DATA_W (BW)
    ) u_hist (
        .clk   (clk),
        .we    (s1_adv && s1_wr_reg),
        .waddr (s1_addr_reg),
        .wdata (s1_data),
        .re    (accept && rd_en),
        .raddr (src_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            cnt_reg       <= '0;
            phase_reg     <= PH_IDLE;
            p0_reg        <= '0;
            p1_reg        <= '0;
            off_reg       <= '0;
            rem_reg       <= '0;
            esc_reg       <= lzd_pkg::ESCAPE_RST;
            cpy_reg       <= lzd_pkg::COPY_RST;
            s1_valid_reg  <= 1'b0;
            s1_wr_reg     <= 1'b0;
            s1_lit_reg    <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (lzd_pkg::cfg_reg_t'(cfg_index))
                    lzd_pkg::REG_ESCAPE: esc_reg <= cfg_wdata;
                    lzd_pkg::REG_COPY:   cpy_reg <= cfg_wdata;
                    default:             esc_reg <= esc_reg;
                endcase
            end

            if (accept)
            begin
                wp_reg     <= wp_next;
                cnt_reg    <= cnt_next;
                phase_reg  <= phase_next;
                p0_reg     <= p0_next;
                p1_reg     <= p1_next;
                off_reg    <= off_next;
                rem_reg    <= rem_next;
                s1_wr_reg  <= s1_wr_next;
                s1_lit_reg <= s1_lit_next;
                s1_fwd_reg <= rd_en && fwd_hit;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg   <= in_byte;
            s1_addr_reg   <= wp_reg;
            s1_left_reg   <= rem_next;
            s1_status_reg <= s1_status_next;
        end
        if (s1_adv)
        begin
            m_outv_reg   <= s1_wr_reg;
            m_byte_reg   <= s1_wr_reg ? s1_data : '0;
            m_left_reg   <= s1_left_reg;
            m_status_reg <= s1_status_reg;
        end
        if (s1_adv && s1_wr_reg)
        begin
            last_wd_reg <= s1_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_outv_reg;
    assign m_tdata  = {2'b00, m_status_reg, m_left_reg, m_byte_reg};

endmodule

@@ rtl/lzd_hist_ram.sv @@
// lzd_hist_ram: history window storage, one write and one read port.
// Read data is registered and only updated on a read enable.
// Uses no package items.
module lzd_hist_ram #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned ADDR_W = 12,
    parameter int unsigned DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // old data on a same-address read; the caller forwards around it
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
